FILE: hdl/assert_macros.svh
// Assertion macros used by the scanner top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_SAME_CYCLE(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CHK_NEXT_CYCLE(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CHK_SAME_CYCLE(label, ante, cons, msg)
`define CHK_NEXT_CYCLE(label, ante, cons, msg)
`endif
`endif

FILE: hdl/mbps_pkg.sv
package mbps_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int HIT_LIMIT   = 2;
  localparam int LEN_W       = 5;
  localparam int ADDR_W      = 64;
  localparam int MASK_W      = 16;
  localparam int CNT_W       = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int LOW_W       = $clog2(PATTERN_MAX);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_BYTE_MASK      = 3'd2,
    CFG_PATTERN_LENGTH = 3'd3,
    CFG_BASE_ADDRESS   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_end;
  } in_beat_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] hit_address;
    logic              ambiguous;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] pat_byte;
    logic       care;
  } cell_ref_t;

endpackage

FILE: hdl/masked_byte_pattern_scan_top.sv
// Masked byte pattern scanner.
// The input channel (in_valid, in_stall, in_data) carries one byte of a region per beat, in
// address order; region_end marks the region's last byte. After each byte the window of
// pattern_length bytes ending there is compared against the pattern, with cleared byte_mask
// bits acting as wildcards. On the last byte one result beat goes out on the output channel
// (out_valid, out_stall, out_data): found, the base address plus offset of the first match,
// and ambiguous when two or more windows matched. The scan state then clears for the next
// region. Bytes that are not the last of a region give no result.
// Every cycle a byte is accepted, but a region's last byte waits while a result is held;
// the result is registered and appears in the cycle after the last byte. Throughput is one
// byte per clock, set by sixteen shift cells, each comparing its incoming byte in parallel.
// Configuration is written through cfg_we, cfg_index and cfg_wdata at any edge; writes to
// indexes past the base address register are ignored.
// Synchronous reset clears the configuration, the match count, the byte count and the output
// valid flag. The window bytes need no reset, as only bytes of the current region are compared.
// While a result is held under out_stall, bytes that do not end a region are still taken;
// a region's last byte waits until the output register is free.
module masked_byte_pattern_scan_top
  import mbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "assert_macros.svh"

  logic [63:0]       pat_low_r;
  logic [63:0]       pat_high_r;
  logic [MASK_W-1:0] mask_r;
  logic [LEN_W-1:0]  len_r;
  logic [ADDR_W-1:0] base_r;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] first_r, first_nxt;
  logic [ADDR_W-1:0] rcv_r;
  logic              out_valid_r;
  out_beat_t         out_data_r, out_data_nxt;

  logic              in_fire;
  logic              out_fire;
  logic [127:0]      pat_all;
  logic [7:0]        pat_bytes [PATTERN_MAX];
  logic [7:0]        win_in    [PATTERN_MAX];
  logic [7:0]        win_q     [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_ok;
  cell_ref_t         cell_ref  [PATTERN_MAX];
  logic              len_ok;
  logic              fill_ok;
  logic              win_match;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign in_stall = out_valid_r && out_stall && in_data.region_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      mask_r     <= '0;
      len_r      <= '0;
      base_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:    pat_low_r  <= cfg_wdata;
        CFG_PATTERN_HIGH:   pat_high_r <= cfg_wdata;
        CFG_BYTE_MASK:      mask_r     <= cfg_wdata[MASK_W-1:0];
        CFG_PATTERN_LENGTH: len_r      <= cfg_wdata[LEN_W-1:0];
        CFG_BASE_ADDRESS:   base_r     <= cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_all = {pat_high_r, pat_low_r};

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      pat_bytes[i] = pat_all[8*i +: 8];
    end
  end

  assign win_in[0] = in_data.data_byte;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [LEN_W-1:0] pidx;

    if (k > 0) begin : g_link
      assign win_in[k] = win_q[k-1];
    end

    // Cell k holds window position k, which lines up with pattern byte len - 1 - k.
    assign pidx = len_r - LEN_W'(k + 1);
    assign cell_ref[k].pat_byte = pat_bytes[pidx[LOW_W-1:0]];
    assign cell_ref[k].care     = (len_r > LEN_W'(k)) && mask_r[pidx[LOW_W-1:0]];

    mbps_cell u_cell (
      .clk      (clk),
      .shift_en (in_fire),
      .byte_in  (win_in[k]),
      .ref_in   (cell_ref[k]),
      .byte_q   (win_q[k]),
      .match_ok (cell_ok[k])
    );
  end

  // rcv_r counts the bytes of the region including the one being accepted.
  assign len_ok    = (len_r != '0) && (len_r <= LEN_W'(PATTERN_MAX));
  assign fill_ok   = (rcv_r[ADDR_W-1:LOW_W] != '0) ||
                     ({{(LEN_W-LOW_W){1'b0}}, rcv_r[LOW_W-1:0]} >= len_r);
  assign win_match = len_ok && fill_ok && (&cell_ok);

  always_comb begin
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    if (win_match) begin
      if (cnt_r == '0) begin
        first_nxt = rcv_r - {{(ADDR_W-LEN_W){1'b0}}, len_r};
      end
      if (cnt_r < CNT_W'(HIT_LIMIT)) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    out_data_nxt.found       = (cnt_nxt != '0);
    out_data_nxt.hit_address = (cnt_nxt != '0) ? base_r + first_nxt : '0;
    out_data_nxt.ambiguous   = (cnt_nxt >= CNT_W'(HIT_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      first_r     <= '0;
      rcv_r       <= ADDR_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        if (in_data.region_end) begin
          cnt_r   <= '0;
          first_r <= '0;
          rcv_r   <= ADDR_W'(1);
        end else begin
          cnt_r   <= cnt_nxt;
          first_r <= first_nxt;
          rcv_r   <= rcv_r + ADDR_W'(1);
        end
      end
      if (in_fire && in_data.region_end) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.region_end) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CHK_SAME_CYCLE(a_cnt_saturates, 1'b1, cnt_r <= CNT_W'(HIT_LIMIT), "match count past limit")
  `CHK_NEXT_CYCLE(a_last_clears, in_fire && in_data.region_end,
    out_valid_r && (cnt_r == '0) && (rcv_r == ADDR_W'(1)), "region end did not clear scan")
  `CHK_SAME_CYCLE(a_none_zero_addr, out_valid_r && !out_data_r.found,
    (out_data_r.hit_address == '0) && !out_data_r.ambiguous, "empty result not zero")
  `CHK_SAME_CYCLE(a_stall_cause, in_stall, out_valid_r && out_stall, "input stalled without cause")

endmodule

FILE: hdl/mbps_cell.sv
module mbps_cell
  import mbps_pkg::*;
(
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  input  cell_ref_t  ref_in,
  output logic [7:0] byte_q,
  output logic       match_ok
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  // The cell checks the byte that enters it, which is its window position after the shift.
  assign match_ok = !ref_in.care || (byte_in == ref_in.pat_byte);
  assign byte_q   = byte_r;

endmodule
